[sv/float_to_decimal_text_macros.svh]
// Assertion macros shared by the float-to-decimal text printer.
// Uses the clk and rst_n signals of the module that includes it.
`ifndef FLOAT_TO_DECIMAL_TEXT_MACROS_SVH
`define FLOAT_TO_DECIMAL_TEXT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FTD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ftd_pkg.sv]
// Package for the float-to-decimal text printer: widths, ASCII codes,
// exponent thresholds, sequencer states and converter handshake structs.
package ftd_pkg;

    localparam int INT_W          = 32;
    localparam int BCD_DIGITS     = 10;
    localparam int BCD_W          = 4 * BCD_DIGITS;
    localparam int DIGIT_IDX_W    = 4;
    localparam int FRAC_W         = 64;
    localparam int MANT_W         = 24;
    localparam int PLACES_W       = 4;
    localparam int MAX_PLACES_DEF = 9;

    // ASCII codes of the fixed characters.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;

    // Biased exponent thresholds.
    localparam logic [7:0] EXP_SPECIAL   = 8'hFF;
    localparam logic [7:0] EXP_SAT       = 8'd159;
    localparam logic [7:0] EXP_UNITY     = 8'd150;
    localparam logic [7:0] EXP_SUB_SHIFT = 8'd149;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_INT,
        S_POINT,
        S_FRAC
    } state_t;

    typedef struct packed {
        logic             start;
        logic [INT_W-1:0] value;
    } conv_req_t;

    typedef struct packed {
        logic                   done;
        logic [DIGIT_IDX_W-1:0] top_idx;
    } conv_sts_t;

endpackage

[sv/ftd_bin2bcd.sv]
// Iterative binary to BCD converter (shift and add-three), one bit a cycle.
// Depends on ftd_pkg for widths and the request and status structs.
module ftd_bin2bcd
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ftd_pkg::conv_req_t            req,
    output logic [ftd_pkg::BCD_W-1:0]     bcd,
    output ftd_pkg::conv_sts_t            sts
);

    localparam int STEP_W = $clog2(ftd_pkg::INT_W);

    logic [ftd_pkg::INT_W-1:0] bin_reg;
    logic [ftd_pkg::INT_W-1:0] bin_next;
    logic [ftd_pkg::BCD_W-1:0] bcd_reg;
    logic [ftd_pkg::BCD_W-1:0] bcd_next;
    logic [ftd_pkg::BCD_W-1:0] adj;
    logic [STEP_W-1:0]         cnt_reg;
    logic [STEP_W-1:0]         cnt_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      done_reg;
    logic                      done_next;
    logic                      last_step;
    logic [ftd_pkg::DIGIT_IDX_W-1:0] top_idx;

    // Add three to every BCD digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < ftd_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign last_step = (cnt_reg == STEP_W'(ftd_pkg::INT_W - 1));

    // Load on a request, otherwise shift one binary bit into the BCD word.
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            bin_next  = req.value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bin_next = {bin_reg[ftd_pkg::INT_W-2:0], 1'b0};
            bcd_next = {adj[ftd_pkg::BCD_W-2:0], bin_reg[ftd_pkg::INT_W-1]};
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // Position of the most significant non-zero digit; zero gives digit 0.
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < ftd_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                top_idx = ftd_pkg::DIGIT_IDX_W'(i);
            end
        end
    end

    assign bcd         = bcd_reg;
    assign sts.done    = done_reg;
    assign sts.top_idx = top_idx;

endmodule

[sv/float_to_decimal_text.sv]
// Float-to-decimal text printer: single-precision pattern in, ASCII characters out.
// An item is accepted only while the sequencer is idle; its integer part goes through the 32-step
// shift-and-add-three integer converter before its first character; fraction digits come
// one a cycle while the output is not stalled.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// Depends on ftd_pkg, ftd_bin2bcd and float_to_decimal_text_macros.svh.
`include "float_to_decimal_text_macros.svh"

module float_to_decimal_text
#(
    parameter int MAX_PLACES = ftd_pkg::MAX_PLACES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [31:0]                    value_bits,
    input  logic [ftd_pkg::PLACES_W-1:0]   decimal_places,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     character,
    output logic                           last_char,
    output logic                           saturated
);

    ftd_pkg::state_t state_reg;
    ftd_pkg::state_t state_next;

    logic                            accept;
    logic                            out_free;

    // Decoded fields of the incoming item.
    logic [7:0]                      expf;
    logic [22:0]                     mant;
    logic [ftd_pkg::MANT_W-1:0]      mfull;
    logic [7:0]                      fshift;
    logic                            is_zero;
    logic                            is_nan;
    logic                            dec_neg;
    logic                            dec_sat;
    logic [ftd_pkg::INT_W-1:0]       dec_ipart;
    logic [ftd_pkg::FRAC_W-1:0]      dec_frac;
    logic [ftd_pkg::PLACES_W-1:0]    dec_places;

    // Per-item working registers.
    logic                            neg_reg;
    logic                            sat_reg;
    logic [ftd_pkg::PLACES_W-1:0]    plc_reg;
    logic [ftd_pkg::FRAC_W-1:0]      frac_reg;
    logic [ftd_pkg::DIGIT_IDX_W-1:0] idx_reg;

    // Converter handshake.
    ftd_pkg::conv_req_t              conv_req;
    ftd_pkg::conv_sts_t              conv_sts;
    logic [ftd_pkg::BCD_W-1:0]       bcd;

    // Fraction step and integer digit selection.
    logic [ftd_pkg::FRAC_W+3:0]      prod;
    logic [3:0]                      int_digit;

    // Character emission controls.
    logic                            emit;
    logic [7:0]                      emit_char;
    logic                            emit_last;

    // Output register.
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [7:0]                      char_reg;
    logic                            last_reg;
    logic                            sat_out_reg;

    assign in_stall = (state_reg != ftd_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Split the bit pattern into integer part and 64-bit binary fraction.
    always_comb
    begin
        expf    = value_bits[30:23];
        mant    = value_bits[22:0];
        mfull   = {(expf != 8'd0), mant};
        is_zero = (expf == 8'd0) && (mant == 23'd0);
        is_nan  = (expf == ftd_pkg::EXP_SPECIAL) && (mant != 23'd0);
        dec_neg = value_bits[31] && !is_zero && !is_nan;
        dec_sat   = 1'b0;
        dec_ipart = '0;
        dec_frac  = '0;
        fshift    = '0;
        if ((expf == ftd_pkg::EXP_SPECIAL) || (expf >= ftd_pkg::EXP_SAT))
        begin
            dec_sat   = 1'b1;
            dec_ipart = '1;
        end
        else if (expf >= ftd_pkg::EXP_UNITY)
        begin
            dec_ipart = ftd_pkg::INT_W'({8'd0, mfull} << 4'(expf - ftd_pkg::EXP_UNITY));
        end
        else
        begin
            if (expf == 8'd0)
            begin
                fshift = ftd_pkg::EXP_SUB_SHIFT;
            end
            else
            begin
                fshift = ftd_pkg::EXP_UNITY - expf;
            end
            if (fshift < 8'd24)
            begin
                dec_ipart = ftd_pkg::INT_W'(mfull >> fshift[4:0]);
            end
            // Align the remainder bits to the top of a 64-bit fraction.
            if (fshift < 8'd64)
            begin
                dec_frac = {40'd0, mfull} << 6'(7'd64 - {1'b0, fshift[5:0]});
            end
        end
        if (decimal_places > ftd_pkg::PLACES_W'(MAX_PLACES))
        begin
            dec_places = ftd_pkg::PLACES_W'(MAX_PLACES);
        end
        else
        begin
            dec_places = decimal_places;
        end
    end

    assign conv_req.start = accept;
    assign conv_req.value = dec_ipart;

    ftd_bin2bcd u_bin2bcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (conv_req),
        .bcd   (bcd),
        .sts   (conv_sts)
    );

    // Fraction times ten: the carry out is the next digit.
    assign prod      = ({4'd0, frac_reg} << 3) + ({4'd0, frac_reg} << 1);
    assign int_digit = bcd[{idx_reg, 2'b00} +: 4];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ftd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ftd_pkg::S_CONV;
                end
            end
            ftd_pkg::S_CONV:
            begin
                if (conv_sts.done)
                begin
                    state_next = neg_reg ? ftd_pkg::S_SIGN : ftd_pkg::S_INT;
                end
            end
            ftd_pkg::S_SIGN:
            begin
                if (out_free)
                begin
                    state_next = ftd_pkg::S_INT;
                end
            end
            ftd_pkg::S_INT:
            begin
                if (out_free && (idx_reg == '0))
                begin
                    state_next = (plc_reg != '0) ? ftd_pkg::S_POINT : ftd_pkg::S_IDLE;
                end
            end
            ftd_pkg::S_POINT:
            begin
                if (out_free)
                begin
                    state_next = ftd_pkg::S_FRAC;
                end
            end
            ftd_pkg::S_FRAC:
            begin
                if (out_free && (plc_reg == ftd_pkg::PLACES_W'(1)))
                begin
                    state_next = ftd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ftd_pkg::S_IDLE;
            end
        endcase
    end

    // Output logic: which character goes to the output register.
    always_comb
    begin
        emit      = 1'b0;
        emit_char = ftd_pkg::CH_ZERO;
        emit_last = 1'b0;
        unique case (state_reg)
            ftd_pkg::S_SIGN:
            begin
                emit      = out_free;
                emit_char = ftd_pkg::CH_MINUS;
            end
            ftd_pkg::S_INT:
            begin
                emit      = out_free;
                emit_char = ftd_pkg::CH_ZERO + {4'd0, int_digit};
                emit_last = (idx_reg == '0) && (plc_reg == '0);
            end
            ftd_pkg::S_POINT:
            begin
                emit      = out_free;
                emit_char = ftd_pkg::CH_POINT;
            end
            ftd_pkg::S_FRAC:
            begin
                emit      = out_free;
                emit_char = ftd_pkg::CH_ZERO + {4'd0, prod[ftd_pkg::FRAC_W+3:ftd_pkg::FRAC_W]};
                emit_last = (plc_reg == ftd_pkg::PLACES_W'(1));
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Output valid: set on a new character, cleared once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ftd_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Per-item working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg  <= dec_neg;
            sat_reg  <= dec_sat;
            plc_reg  <= dec_places;
            frac_reg <= dec_frac;
        end
        if ((state_reg == ftd_pkg::S_CONV) && conv_sts.done)
        begin
            idx_reg <= conv_sts.top_idx;
        end
        if ((state_reg == ftd_pkg::S_INT) && emit && (idx_reg != '0))
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        if ((state_reg == ftd_pkg::S_FRAC) && emit)
        begin
            frac_reg <= prod[ftd_pkg::FRAC_W-1:0];
            plc_reg  <= plc_reg - 1'b1;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg    <= emit_char;
            last_reg    <= emit_last;
            sat_out_reg <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;
    assign saturated = sat_out_reg;

    // Checks on the sequencer.
    `FTD_ASSERT_IMPL(a_done_in_conv, conv_sts.done, state_reg == ftd_pkg::S_CONV, "converter finished outside the conversion state")
    `FTD_ASSERT_NEXT(a_last_to_idle, emit && emit_last, state_reg == ftd_pkg::S_IDLE, "final character did not return the sequencer to idle")
    `FTD_ASSERT_IMPL(a_idx_range, state_reg == ftd_pkg::S_INT, idx_reg <= ftd_pkg::DIGIT_IDX_W'(ftd_pkg::BCD_DIGITS - 1), "integer digit index out of range")
    `FTD_ASSERT_IMPL(a_frac_count, state_reg == ftd_pkg::S_FRAC, plc_reg != '0, "fraction digit emitted with no places left")

endmodule
